FILE: hw/rtl/crc_pkg.sv
package crc_pkg;

    localparam int MAX_CH = 8;

    localparam logic [2:0] FUNC_CLK_LOW  = 3'd0;
    localparam logic [2:0] FUNC_CLK_HIGH = 3'd1;
    localparam logic [2:0] FUNC_RESET    = 3'd2;
    localparam logic [2:0] FUNC_PUSH     = 3'd3;
    localparam logic [2:0] FUNC_STOP     = 3'd4;
    localparam logic [2:0] FUNC_LOAD     = 3'd5;

    localparam logic [2:0] RULE_NONE = 3'd0;
    localparam logic [2:0] RULE_INC  = 3'd1;
    localparam logic [2:0] RULE_DEC  = 3'd2;
    localparam logic [2:0] RULE_MAX  = 3'd3;
    localparam logic [2:0] RULE_MIN  = 3'd4;
    localparam logic [2:0] RULE_RAND = 3'd5;
    localparam logic [2:0] RULE_POLE = 3'd6;
    localparam logic [2:0] RULE_STOP = 3'd7;

    localparam logic [2:0] REG_TRIGGER = 3'd0;
    localparam logic [2:0] REG_TOGGLE  = 3'd1;
    localparam logic [2:0] REG_SYNC    = 3'd2;
    localparam logic [2:0] REG_RULE    = 3'd3;
    localparam logic [2:0] REG_LBOUND  = 3'd4;
    localparam logic [2:0] REG_SBOUND  = 3'd5;
    localparam logic [2:0] REG_INIT    = 3'd6;
    localparam logic [2:0] REG_SEED    = 3'd7;

    // commands from controller to datapath
    typedef struct packed {
        logic       start;      // latch item, run non-clock function
        logic       push_step;  // fire masks of pending push for cur channel
        logic       tick_step;  // tick / step / rule of cur channel
        logic       mask_step;  // fire masks after rule of cur channel
        logic       rand_step;  // one remainder iteration for random rule
        logic       rand_done;  // write random result
        logic [2:0] cur;
    } crc_cmd_t;

    typedef struct packed {
        logic fire;      // channel fired in tick step
        logic rand_req;  // rule needs random remainder
        logic rand_busy; // remainder not finished
    } crc_stat_t;

endpackage

FILE: hw/rtl/crc_datapath.sv
module crc_datapath
    import crc_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  crc_cmd_t      cmd,
    output crc_stat_t     stat,
    input  logic [2:0]    item_func,
    input  logic [2:0]    item_channel,
    input  logic [63:0]   trig_m,
    input  logic [63:0]   togg_m,
    input  logic [63:0]   sync_m,
    input  logic [63:0]   rule_t,
    input  logic [63:0]   lbound,
    input  logic [47:0]   sbound,
    input  logic [55:0]   init_s,
    input  logic          seed_wr,
    input  logic [31:0]   seed_val,
    output logic [7:0]    gates,
    output logic [39:0]   positions,
    output logic [31:0]   lengths,
    output logic [23:0]   speeds
);

    logic signed [4:0] pos_reg  [MAX_CH];
    logic signed [4:0] pos_next [MAX_CH];
    logic [2:0] tick_reg [MAX_CH];
    logic [2:0] tick_next[MAX_CH];
    logic [3:0] len_reg  [MAX_CH];
    logic [3:0] len_next [MAX_CH];
    logic [2:0] spd_reg  [MAX_CH];
    logic [2:0] spd_next [MAX_CH];
    logic [7:0] push_reg, push_next, gate_reg, gate_next, clr_reg, clr_next;
    logic [31:0] rnd_reg, rnd_next;
    // serial remainder: rem of x mod m, one bit a cycle
    logic [31:0] rx_reg, rx_next;
    logic [4:0]  rm_reg, rm_next;
    logic [5:0]  rcnt_reg, rcnt_next;
    logic [3:0]  rlo_reg, rlo_next;
    logic [4:0]  rr_reg, rr_next;
    logic [1:0]  rtg_reg, rtg_next;
    logic [2:0]  rd_reg, rd_next;

    logic [7:0] cb, sy, tr, tg;
    logic [2:0] rule, dst;
    logic [1:0] tgt;
    logic [3:0] lmn, lmx, lv, lres;
    logic [2:0] smn, smx, sv, sres;
    logic [31:0] xr, x1, x2, x3;
    logic [5:0] rsh;
    logic dst_ok;

    function automatic logic [3:0] rule_fn(input logic [2:0] r, input logic [3:0] v,
                                            input logic [3:0] lo, input logic [3:0] hi);
        logic [4:0] dlo, dhi;
        begin
            dlo = (v >= lo) ? {1'b0, v - lo} : {1'b0, lo - v};
            dhi = (v >= hi) ? {1'b0, v - hi} : {1'b0, hi - v};
            unique case (r)
                RULE_INC:  rule_fn = (v >= hi) ? lo : v + 4'd1;
                RULE_DEC:  rule_fn = (v <= lo) ? hi : v - 4'd1;
                RULE_MAX:  rule_fn = hi;
                RULE_MIN:  rule_fn = lo;
                RULE_POLE: rule_fn = (dlo < dhi) ? hi : lo;
                default:   rule_fn = v;
            endcase
        end
    endfunction

    always_comb
    begin
        cb   = rule_t[8*cmd.cur +: 8];
        rule = cb[2:0];
        dst  = cb[5:3];
        tgt  = cb[7:6];
        dst_ok = (32'(dst) < CHANNELS);
        lmn = lbound[8*dst +: 4];
        lmx = lbound[8*dst+4 +: 4];
        smn = sbound[6*dst +: 3];
        smx = sbound[6*dst+3 +: 3];
        lv  = len_reg[dst];
        sv  = spd_reg[dst];
        lres = rule_fn(rule, lv, lmn, lmx);
        sres = 3'(rule_fn(rule, {1'b0, sv}, {1'b0, smn}, {1'b0, smx}));
        xr = (rnd_reg == 32'd0) ? 32'd1 : rnd_reg;
        x1 = xr ^ (xr << 13);
        x2 = x1 ^ (x1 >> 17);
        x3 = x2 ^ (x2 << 5);
        sy = sync_m[8*cmd.cur +: 8];
        tr = trig_m[8*cmd.cur +: 8];
        tg = togg_m[8*cmd.cur +: 8];
        rsh = {rr_reg, rx_reg[31]};
    end

    always_comb
    begin
        logic fire_m;
        fire_m = 1'b0;
        for (int i = 0; i < MAX_CH; i++)
        begin
            pos_next[i]  = pos_reg[i];
            tick_next[i] = tick_reg[i];
            len_next[i]  = len_reg[i];
            spd_next[i]  = spd_reg[i];
        end
        push_next = push_reg;
        gate_next = gate_reg;
        clr_next  = clr_reg;
        rnd_next  = rnd_reg;
        rx_next = rx_reg; rm_next = rm_reg; rcnt_next = rcnt_reg;
        rlo_next = rlo_reg; rr_next = rr_reg; rtg_next = rtg_reg; rd_next = rd_reg;
        stat = '0;
        stat.rand_busy = (rcnt_reg != 6'd0);

        if (seed_wr)
            rnd_next = (seed_val == 32'd0) ? 32'd1 : seed_val;

        if (cmd.start)
        begin
            unique case (item_func)
                FUNC_CLK_LOW:
                begin
                    gate_next = gate_reg & ~clr_reg;
                    clr_next  = '0;
                end
                FUNC_RESET:
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        pos_next[i]  = 5'(len_reg[i]);
                        tick_next[i] = spd_reg[i];
                    end
                FUNC_PUSH:
                    if (32'(item_channel) < CHANNELS)
                        push_next[item_channel] = 1'b1;
                FUNC_STOP:
                    if (32'(item_channel) < CHANNELS)
                        pos_next[item_channel] = (pos_reg[item_channel] == -5'sd1) ?
                            5'(len_reg[item_channel]) : -5'sd1;
                FUNC_LOAD:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        len_next[i]  = init_s[4*i +: 4];
                        spd_next[i]  = init_s[32+3*i +: 3];
                        pos_next[i]  = 5'(init_s[4*i +: 4]);
                        tick_next[i] = '0;
                    end
                    push_next = '0;
                    clr_next  = '0;
                    gate_next = '0;
                end
                default: ;
            endcase
        end

        if (cmd.push_step && push_reg[cmd.cur])
        begin
            fire_m = 1'b1;
            push_next[cmd.cur] = 1'b0;
        end

        if (cmd.tick_step)
        begin
            if (tick_reg[cmd.cur] == 3'd0)
            begin
                tick_next[cmd.cur] = spd_reg[cmd.cur];
                if (pos_reg[cmd.cur] == 5'sd0)
                begin
                    stat.fire = 1'b1;
                    pos_next[cmd.cur] = -5'sd1;
                    if (dst_ok && rule == RULE_STOP)
                    begin
                        if (tgt[0])
                        begin
                            // stop on self lands on -2 after the step
                            if (dst == cmd.cur) pos_next[cmd.cur] = -5'sd2;
                            else pos_next[dst] = -5'sd1;
                        end
                    end
                    else if (dst_ok && rule == RULE_RAND)
                    begin
                        // first target draws now, speed draws later if both
                        stat.rand_req = |tgt;
                        rtg_next = tgt;
                        rd_next = dst;
                        if (tgt[0])
                        begin
                            rnd_next = x3;
                            rlo_next = lmn;
                            rm_next  = (lmx < lmn) ? 5'd1 : 5'(lmx) - 5'(lmn) + 5'd1;
                        end
                        else if (tgt[1])
                        begin
                            rnd_next = x3;
                            rlo_next = {1'b0, smn};
                            rm_next  = (smx < smn) ? 5'd1 : 5'(smx) - 5'(smn) + 5'd1;
                        end
                        rx_next = x3; rr_next = '0; rcnt_next = 6'd32;
                    end
                    else if (dst_ok && rule != RULE_NONE)
                    begin
                        if (tgt[0]) len_next[dst] = lres;
                        if (tgt[1]) spd_next[dst] = sres;
                    end
                end
                else if (pos_reg[cmd.cur] > 5'sd0)
                    pos_next[cmd.cur] = pos_reg[cmd.cur] - 5'sd1;
            end
            else
                tick_next[cmd.cur] = tick_reg[cmd.cur] - 3'd1;
        end

        if (cmd.rand_step)
        begin
            if (rcnt_reg != 6'd0)
            begin
                rr_next = (rsh >= {1'b0, rm_reg}) ? 5'(rsh - {1'b0, rm_reg}) : rsh[4:0];
                rx_next = rx_reg << 1;
                rcnt_next = rcnt_reg - 6'd1;
            end
        end

        if (cmd.rand_done)
        begin
            if (rtg_reg[0])
            begin
                len_next[rd_reg] = rlo_reg + rr_reg[3:0];
                rtg_next[0] = 1'b0;
                if (rtg_reg[1])
                begin
                    rnd_next = x3;
                    rx_next = x3; rr_next = '0; rcnt_next = 6'd32;
                    rlo_next = {1'b0, sbound[6*rd_reg +: 3]};
                    rm_next = (sbound[6*rd_reg+3 +: 3] < sbound[6*rd_reg +: 3]) ? 5'd1 :
                        5'(sbound[6*rd_reg+3 +: 3]) - 5'(sbound[6*rd_reg +: 3]) + 5'd1;
                    stat.rand_req = 1'b1;
                end
            end
            else if (rtg_reg[1])
            begin
                spd_next[rd_reg] = 3'(rlo_reg + rr_reg[3:0]);
                rtg_next[1] = 1'b0;
            end
        end

        if (cmd.mask_step || fire_m)
        begin
            for (int n = 0; n < CHANNELS; n++)
            begin
                if (sy[n])
                begin
                    pos_next[n]  = 5'(len_next[n]);
                    tick_next[n] = spd_next[n];
                end
                if (tr[n])
                begin
                    gate_next[n] = 1'b1;
                    clr_next[n]  = 1'b1;
                end
                else if (tg[n])
                    gate_next[n] = ~gate_next[n];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CH; i++)
            begin
                pos_reg[i]  <= '0;
                tick_reg[i] <= '0;
                len_reg[i]  <= '0;
                spd_reg[i]  <= '0;
            end
            push_reg <= '0;
            gate_reg <= '0;
            clr_reg  <= '0;
            rnd_reg  <= 32'd1;
            rtg_reg  <= '0;
            rcnt_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_CH; i++)
            begin
                pos_reg[i]  <= pos_next[i];
                tick_reg[i] <= tick_next[i];
                len_reg[i]  <= len_next[i];
                spd_reg[i]  <= spd_next[i];
            end
            push_reg <= push_next;
            gate_reg <= gate_next;
            clr_reg  <= clr_next;
            rnd_reg  <= rnd_next;
            rtg_reg  <= rtg_next;
            rcnt_reg <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg  <= rx_next;
        rm_reg  <= rm_next;
        rlo_reg <= rlo_next;
        rr_reg  <= rr_next;
        rd_reg  <= rd_next;
    end

    always_comb
    begin
        gates = '0; positions = '0; lengths = '0; speeds = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            gates[i]            = gate_reg[i];
            positions[5*i +: 5] = pos_reg[i];
            lengths[4*i +: 4]   = len_reg[i];
            speeds[3*i +: 3]    = spd_reg[i];
        end
    end

endmodule

FILE: hw/rtl/crc_ctrl.sv
module crc_ctrl
    import crc_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [2:0] in_func,
    input  logic       out_fire,
    output logic       in_ready,
    output logic       out_valid,
    output logic       load_item,
    input  crc_stat_t  stat,
    output crc_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PUSH  = 3'd1;
    localparam logic [2:0] ST_TICK  = 3'd2;
    localparam logic [2:0] ST_RAND  = 3'd3;
    localparam logic [2:0] ST_MASK  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] cur_reg, cur_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign load_item = in_fire;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        cmd = '0;
        cmd.cur = cur_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    cmd.start = 1'b1;
                    cur_next = '0;
                    state_next = (in_func == FUNC_CLK_HIGH) ? ST_PUSH : ST_OUT;
                end
            ST_PUSH:
            begin
                cmd.push_step = 1'b1;
                state_next = ST_TICK;
            end
            ST_TICK:
            begin
                cmd.tick_step = 1'b1;
                if (stat.rand_req) state_next = ST_RAND;
                else if (stat.fire) state_next = ST_MASK;
                else if (32'(cur_reg) == CHANNELS - 1) state_next = ST_OUT;
                else
                begin
                    cur_next = cur_reg + 3'd1;
                    state_next = ST_PUSH;
                end
            end
            ST_RAND:
            begin
                cmd.rand_step = 1'b1;
                if (!stat.rand_busy)
                begin
                    cmd.rand_step = 1'b0;
                    cmd.rand_done = 1'b1;
                    if (!stat.rand_req) state_next = ST_MASK;
                end
            end
            ST_MASK:
            begin
                cmd.mask_step = 1'b1;
                if (32'(cur_reg) == CHANNELS - 1) state_next = ST_OUT;
                else
                begin
                    cur_next = cur_reg + 3'd1;
                    state_next = ST_PUSH;
                end
            end
            ST_OUT:
                if (out_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cur_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
        end
    end

endmodule

FILE: hw/rtl/cascading_rule_counters_top.sv
// cascading rule counters: up to eight cascading down-counters with prescaler ticks,
// driven by a stream of clock/control items (s_axis_tdata: func[2:0], channel[5:3]).
// every item returns one result item with the gate, position, length and speed of
// all channels. a non-clock item is accepted, then its result is offered; a clock-high
// item walks the channels one at a time, with a push and a tick step each, a mask step
// for a channel that fires, and a bit-serial remainder run for every random rule target
// (one bit a cycle) before its result is ready.
// configuration registers sit at byte address 8*i on the apb port; the user must write
// them only while the block is idle, which the block itself does not enforce.
module cascading_rule_counters_top
    import crc_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // func[2:0], channel[5:3]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // gates[7:0], positions[47:8],
                                         // lengths[79:48], speeds[103:80]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [63:0] trig_reg, togg_reg, sync_reg, rule_reg, lb_reg;
    logic [47:0] sb_reg;
    logic [55:0] init_reg;
    logic [31:0] seed_reg;
    logic [2:0]  func_reg, chan_reg;
    logic        wr, in_fire, out_fire, load_item;
    logic [2:0]  ridx;
    crc_cmd_t    cmd;
    crc_stat_t   stat;
    logic [7:0]  gates;
    logic [39:0] positions;
    logic [31:0] lengths;
    logic [23:0] speeds;

    assign pready   = 1'b1;
    assign wr       = psel && penable && pwrite && pready;
    assign ridx     = paddr[5:3];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_reg <= 64'h8040201008040201;
            togg_reg <= '0;
            sync_reg <= 64'h8040201008040201;
            rule_reg <= '0;
            lb_reg   <= '0;
            sb_reg   <= '0;
            init_reg <= '0;
            seed_reg <= 32'd1;
        end
        else if (wr && paddr[2:0] == 3'd0)
        begin
            unique case (ridx)
                REG_TRIGGER: trig_reg <= pwdata;
                REG_TOGGLE:  togg_reg <= pwdata;
                REG_SYNC:    sync_reg <= pwdata;
                REG_RULE:    rule_reg <= pwdata;
                REG_LBOUND:  lb_reg   <= pwdata;
                REG_SBOUND:  sb_reg   <= pwdata[47:0];
                REG_INIT:    init_reg <= pwdata[55:0];
                REG_SEED:    seed_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_TRIGGER: prdata = trig_reg;
            REG_TOGGLE:  prdata = togg_reg;
            REG_SYNC:    prdata = sync_reg;
            REG_RULE:    prdata = rule_reg;
            REG_LBOUND:  prdata = lb_reg;
            REG_SBOUND:  prdata = {16'd0, sb_reg};
            REG_INIT:    prdata = {8'd0, init_reg};
            REG_SEED:    prdata = {32'd0, seed_reg};
            default:     prdata = '0;
        endcase
    end

    // item fields held for the whole walk
    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            func_reg <= s_axis_tdata[2:0];
            chan_reg <= s_axis_tdata[5:3];
        end
    end

    crc_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_func   (s_axis_tdata[2:0]),
        .out_fire  (out_fire),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .load_item (load_item),
        .stat      (stat),
        .cmd       (cmd)
    );

    // non-clock functions run in the accept cycle straight from the bus
    crc_datapath #(.CHANNELS(CHANNELS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item_func    (cmd.start ? s_axis_tdata[2:0] : func_reg),
        .item_channel (cmd.start ? s_axis_tdata[5:3] : chan_reg),
        .trig_m       (trig_reg),
        .togg_m       (togg_reg),
        .sync_m       (sync_reg),
        .rule_t       (rule_reg),
        .lbound       (lb_reg),
        .sbound       (sb_reg),
        .init_s       (init_reg),
        .seed_wr      (wr && paddr[2:0] == 3'd0 && ridx == REG_SEED),
        .seed_val     (pwdata[31:0]),
        .gates        (gates),
        .positions    (positions),
        .lengths      (lengths),
        .speeds       (speeds)
    );

    assign m_axis_tdata = {speeds, lengths, positions, gates};

    // never take an item while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // a result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped before taken");

    // an accepted item leaves ready low the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("ready stayed high after accept");

endmodule
